// File: rtl/dscp_pkg.sv
// Shared constants and types for the dual stepper command pulser.
// No dependencies; every other file imports this package.
package dscp_pkg;

    localparam int CNT_W = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_TICK_PERIOD = 2'd0;
    localparam logic [1:0] CFG_DRIVE_STEPS = 2'd1;
    localparam logic [1:0] CFG_TURN_STEPS  = 2'd2;

    localparam logic [CNT_W-1:0] TICK_PERIOD_RST = 16'd2;
    localparam logic [CNT_W-1:0] DRIVE_STEPS_RST = 16'd2000;
    localparam logic [CNT_W-1:0] TURN_STEPS_RST  = 16'd100;

    // item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    // frame header bytes
    localparam logic [7:0] HDR_FIRST  = 8'h78; // 'x'
    localparam logic [7:0] HDR_SECOND = 8'h79; // 'y'
    localparam logic [7:0] HDR_QUIET  = 8'h7a; // 'z'

    // command letters
    localparam logic [7:0] CMD_FORWARD = 8'h6d; // 'm'
    localparam logic [7:0] CMD_BACK    = 8'h6e; // 'n'
    localparam logic [7:0] CMD_STOP    = 8'h71; // 'q'
    localparam logic [7:0] CMD_LEFT    = 8'h6f; // 'o'
    localparam logic [7:0] CMD_RIGHT   = 8'h70; // 'p'

    typedef struct packed {
        logic       valid;
        logic [7:0] letter;
    } dscp_cmd_t;

endpackage

// File: rtl/dscp_if.sv
// Handshake channels of the dual stepper command pulser: items, results, configuration.
// Depends on dscp_pkg for widths.
interface dscp_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;
    logic       hold_switch;

    modport source (output valid, kind, rx_byte, hold_switch, input ready);
    modport sink   (input valid, kind, rx_byte, hold_switch, output ready);
endinterface

interface dscp_result_if;
    logic valid;
    logic ready;
    logic right_pulse;
    logic left_pulse;
    logic right_direction;
    logic left_direction;
    logic right_enable_n;
    logic left_enable_n;
    logic right_running;
    logic left_running;
    logic turning;

    modport source (output valid, right_pulse, left_pulse, right_direction, left_direction,
                    right_enable_n, left_enable_n, right_running, left_running, turning,
                    input ready);
    modport sink   (input valid, right_pulse, left_pulse, right_direction, left_direction,
                    right_enable_n, left_enable_n, right_running, left_running, turning,
                    output ready);
endinterface

interface dscp_cfg_if;
    import dscp_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       index;
    logic [CNT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dscp_frame_decoder.sv
// Gathers received bytes into three-byte frames and flags a command letter.
// Depends on dscp_pkg.
module dscp_frame_decoder
    import dscp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output dscp_cmd_t  cmd
);

    logic [1:0] frame_count_reg, frame_count_next;
    logic [7:0] first_byte_reg, first_byte_next;
    logic [7:0] second_byte_reg, second_byte_next;

    always_comb
    begin
        frame_count_next = frame_count_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        cmd.valid        = 1'b0;
        cmd.letter       = rx_byte;
        if (byte_valid)
        begin
            unique case (frame_count_reg)
                2'd0:
                begin
                    first_byte_next  = rx_byte;
                    frame_count_next = 2'd1;
                end
                2'd1:
                begin
                    second_byte_next = rx_byte;
                    frame_count_next = 2'd2;
                end
                default:
                begin
                    // every third byte closes the frame, good header or not
                    frame_count_next = 2'd0;
                    cmd.valid = (first_byte_reg == HDR_FIRST) &&
                                (second_byte_reg == HDR_SECOND);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= 2'd0;
            first_byte_reg  <= 8'd0;
            second_byte_reg <= 8'd0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
        end
    end

    a_frame_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg != 2'd3)
        else $error("frame count out of range");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && frame_count_reg == 2'd2 |=> frame_count_reg == 2'd0)
        else $error("frame did not restart after third byte");

    a_cmd_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> frame_count_reg == 2'd2 && first_byte_reg == HDR_FIRST)
        else $error("command flagged outside a full frame");

endmodule

// File: rtl/dual_stepper_command_pulser.sv
// Dual stepper command pulser: takes 1 ms ticks and serial command bytes, one item a
// cycle, and gives one result beat per item with step pulses, direction, enable and
// status levels for two stepper drivers. Each accepted item updates the state in the
// same cycle and its result sits in an output register; a new item is taken every cycle
// as long as that register is empty or being read, and the result shows in the cycle
// after acceptance. Configuration writes are taken at any time.
// Depends on dscp_pkg, dscp_if and dscp_frame_decoder.
module dual_stepper_command_pulser
    import dscp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    dscp_cfg_if.sink     cfg,
    dscp_item_if.sink    item,
    dscp_result_if.source result
);

    logic [CNT_W-1:0] tick_period_reg, drive_steps_reg, turn_steps_reg;

    logic [CNT_W-1:0] tick_count_reg, tick_count_next;
    logic             left_active_reg, left_active_next;
    logic             right_active_reg, right_active_next;
    logic             left_dir_reg, left_dir_next;
    logic             right_dir_reg, right_dir_next;
    logic [CNT_W-1:0] left_target_reg, left_target_next;
    logic [CNT_W-1:0] right_target_reg, right_target_next;
    logic [CNT_W-1:0] left_done_reg, left_done_next;
    logic [CNT_W-1:0] right_done_reg, right_done_next;
    logic             turn_mode_reg, turn_mode_next;
    logic             left_en_reg, left_en_next;
    logic             right_en_reg, right_en_next;

    logic             out_valid_reg;
    logic             rp_reg, lp_reg;
    logic             rp_next, lp_next;

    logic             accept;
    logic             is_tick;
    logic [CNT_W-1:0] tick_inc;
    logic             step_opp;
    dscp_cmd_t        cmd;

    assign cfg.ready  = 1'b1;
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign is_tick    = item.kind == KIND_TICK;
    assign tick_inc   = tick_count_reg + 16'd1;
    assign step_opp   = is_tick && (tick_inc == tick_period_reg);

    dscp_frame_decoder u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (accept && item.kind == KIND_BYTE),
        .rx_byte    (item.rx_byte),
        .cmd        (cmd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_PERIOD_RST;
            drive_steps_reg <= DRIVE_STEPS_RST;
            turn_steps_reg  <= TURN_STEPS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TICK_PERIOD: tick_period_reg <= cfg.data;
                CFG_DRIVE_STEPS: drive_steps_reg <= cfg.data;
                CFG_TURN_STEPS:  turn_steps_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        tick_count_next   = tick_count_reg;
        left_active_next  = left_active_reg;
        right_active_next = right_active_reg;
        left_dir_next     = left_dir_reg;
        right_dir_next    = right_dir_reg;
        left_target_next  = left_target_reg;
        right_target_next = right_target_reg;
        left_done_next    = left_done_reg;
        right_done_next   = right_done_reg;
        turn_mode_next    = turn_mode_reg;
        left_en_next      = left_en_reg;
        right_en_next     = right_en_reg;
        rp_next           = 1'b0;
        lp_next           = 1'b0;

        if (is_tick)
        begin
            tick_count_next = step_opp ? 16'd0 : tick_inc;
            if (step_opp)
            begin
                if (right_active_reg)
                begin
                    // hold the left driver while the right motor turns
                    if (turn_mode_reg)
                        left_en_next = 1'b0;
                    if (right_done_reg < right_target_reg)
                    begin
                        right_en_next   = 1'b0;
                        right_done_next = right_done_reg + 16'd1;
                        rp_next         = 1'b1;
                    end
                    else
                    begin
                        right_active_next = 1'b0;
                        right_done_next   = 16'd0;
                        right_en_next     = item.hold_switch;
                        if (turn_mode_reg)
                        begin
                            turn_mode_next = 1'b0;
                            left_en_next   = 1'b1;
                        end
                    end
                end
                if (left_active_reg)
                begin
                    if (left_done_reg < left_target_reg)
                    begin
                        left_en_next   = 1'b0;
                        left_done_next = left_done_reg + 16'd1;
                        lp_next        = 1'b1;
                    end
                    else
                    begin
                        left_active_next = 1'b0;
                        left_done_next   = 16'd0;
                        left_en_next     = item.hold_switch;
                    end
                end
            end
        end
        else if (cmd.valid)
        begin
            unique case (cmd.letter)
                CMD_FORWARD:
                begin
                    left_active_next  = 1'b1;
                    left_target_next  = drive_steps_reg;
                    left_dir_next     = 1'b1;
                    right_active_next = 1'b1;
                    right_target_next = drive_steps_reg;
                    right_dir_next    = 1'b0;
                end
                CMD_BACK:
                begin
                    left_active_next  = 1'b1;
                    left_target_next  = drive_steps_reg;
                    left_dir_next     = 1'b0;
                    right_active_next = 1'b1;
                    right_target_next = drive_steps_reg;
                    right_dir_next    = 1'b1;
                end
                CMD_STOP:
                begin
                    left_active_next  = 1'b1;
                    left_target_next  = 16'd0;
                    left_dir_next     = 1'b1;
                    right_active_next = 1'b1;
                    right_target_next = 16'd0;
                    right_dir_next    = 1'b1;
                end
                CMD_LEFT, CMD_RIGHT:
                begin
                    right_active_next = 1'b1;
                    right_target_next = turn_steps_reg;
                    right_dir_next    = cmd.letter == CMD_LEFT;
                    turn_mode_next    = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= 16'd0;
            left_active_reg  <= 1'b0;
            right_active_reg <= 1'b0;
            left_dir_reg     <= 1'b0;
            right_dir_reg    <= 1'b0;
            left_target_reg  <= 16'd0;
            right_target_reg <= 16'd0;
            left_done_reg    <= 16'd0;
            right_done_reg   <= 16'd0;
            turn_mode_reg    <= 1'b0;
            left_en_reg      <= 1'b1;
            right_en_reg     <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tick_count_reg   <= tick_count_next;
                left_active_reg  <= left_active_next;
                right_active_reg <= right_active_next;
                left_dir_reg     <= left_dir_next;
                right_dir_reg    <= right_dir_next;
                left_target_reg  <= left_target_next;
                right_target_reg <= right_target_next;
                left_done_reg    <= left_done_next;
                right_done_reg   <= right_done_next;
                turn_mode_reg    <= turn_mode_next;
                left_en_reg      <= left_en_next;
                right_en_reg     <= right_en_next;
            end
            // advance the result register on every new beat, drop it once taken
            if (accept)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // pulse flags are the only result bits not already kept as state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rp_reg <= rp_next;
            lp_reg <= lp_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.right_pulse     = rp_reg;
    assign result.left_pulse      = lp_reg;
    assign result.right_direction = right_dir_reg;
    assign result.left_direction  = left_dir_reg;
    assign result.right_enable_n  = right_en_reg;
    assign result.left_enable_n   = left_en_reg;
    assign result.right_running   = right_active_reg;
    assign result.left_running    = left_active_reg;
    assign result.turning         = turn_mode_reg;

    a_turn_needs_right: assert property (@(posedge clk) disable iff (!rst_n)
        turn_mode_reg |-> right_active_reg)
        else $error("turn mode without an active right move");

    a_pulse_enables: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (rp_reg || lp_reg) |->
            (!rp_reg || (right_active_reg && !right_en_reg)) &&
            (!lp_reg || (left_active_reg && !left_en_reg)))
        else $error("step pulse on an idle or released motor");

    a_byte_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.kind == KIND_BYTE |=> !rp_reg && !lp_reg)
        else $error("step pulse on a byte beat");

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat left no result");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Testbench for dual_stepper_command_pulser: a directed table, then random tick and frame traffic
// under several register settings, each beat checked against its table row or an in-bench model.
// Depends on dscp_pkg, the channel interfaces in dscp_if and the rtl top level.
module testbench;
    import dscp_pkg::*;

    typedef struct packed {
        logic right_pulse;
        logic left_pulse;
        logic right_direction;
        logic left_direction;
        logic right_enable_n;
        logic left_enable_n;
        logic right_running;
        logic left_running;
        logic turning;
    } motor_levels_t;

    typedef struct packed {
        logic          kind;
        logic [7:0]    val;
        logic          hold;
        logic          typed;
        motor_levels_t want;
    } probe_row_t;

    localparam motor_levels_t AT_REST      = 9'b000011000;
    localparam motor_levels_t STOPPED_HELD = 9'b001100000;
    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int NUM_PHASES      = 7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dscp_item_if   item_ch ();
    dscp_result_if result_ch ();
    dscp_cfg_if    cfg_ch ();

    dual_stepper_command_pulser u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // model state
    logic [15:0] period_cfg, drive_cfg, turn_cfg;
    logic [15:0] ms_count;
    logic [1:0]  byte_slot;
    logic [7:0]  hdr0, hdr1;
    logic        r_act, l_act, r_dir, l_dir, r_en_n, l_en_n, turn_on;
    logic [15:0] r_goal, l_goal, r_steps, l_steps;

    motor_levels_t pending_levels [$];
    int            fault_count    = 0;
    bit            steady         = 1'b0;
    int            hold_off_asked = 0;

    logic [1:0] reg_order [3] = '{CFG_TICK_PERIOD, CFG_DRIVE_STEPS, CFG_TURN_STEPS};
    logic [7:0] cmd_menu [5]  = '{CMD_FORWARD, CMD_BACK, CMD_STOP, CMD_LEFT, CMD_RIGHT};

    logic [15:0] ph_period [NUM_PHASES] = '{16'd1, 16'd2, 16'd3, 16'd5, 16'd1, 16'd65535, 16'd0};
    logic [15:0] ph_drive  [NUM_PHASES] = '{16'd6, 16'd0, 16'd65535, 16'd9, 16'd4, 16'd3, 16'd2000};
    logic [15:0] ph_turn   [NUM_PHASES] = '{16'd3, 16'd65535, 16'd0, 16'd2, 16'd4, 16'd1, 16'd100};
    int          ph_items  [NUM_PHASES] = '{520, 250, 250, 450, 60, 60, 60};

    probe_row_t script [24];

    function automatic void reset_model();
        period_cfg = TICK_PERIOD_RST;
        drive_cfg  = DRIVE_STEPS_RST;
        turn_cfg   = TURN_STEPS_RST;
        ms_count   = '0;
        byte_slot  = '0;
        hdr0       = '0;
        hdr1       = '0;
        r_act      = 1'b0;
        l_act      = 1'b0;
        r_dir      = 1'b0;
        l_dir      = 1'b0;
        r_goal     = '0;
        l_goal     = '0;
        r_steps    = '0;
        l_steps    = '0;
        turn_on    = 1'b0;
        r_en_n     = 1'b1;
        l_en_n     = 1'b1;
    endfunction

    function automatic motor_levels_t predict_levels(logic kind, logic [7:0] b, logic hold);
        logic rp;
        logic lp;
        rp = 1'b0;
        lp = 1'b0;
        if (kind == KIND_BYTE)
        begin
            if (byte_slot == 2'd0)
            begin
                hdr0      = b;
                byte_slot = 2'd1;
            end
            else if (byte_slot == 2'd1)
            begin
                hdr1      = b;
                byte_slot = 2'd2;
            end
            else
            begin
                byte_slot = 2'd0;
                if (hdr0 == HDR_FIRST && hdr1 == HDR_SECOND)
                begin
                    case (b)
                        CMD_FORWARD:
                        begin
                            l_act = 1'b1; l_goal = drive_cfg; l_dir = 1'b1;
                            r_act = 1'b1; r_goal = drive_cfg; r_dir = 1'b0;
                        end
                        CMD_BACK:
                        begin
                            l_act = 1'b1; l_goal = drive_cfg; l_dir = 1'b0;
                            r_act = 1'b1; r_goal = drive_cfg; r_dir = 1'b1;
                        end
                        CMD_STOP:
                        begin
                            l_act = 1'b1; l_goal = '0; l_dir = 1'b1;
                            r_act = 1'b1; r_goal = '0; r_dir = 1'b1;
                        end
                        CMD_LEFT, CMD_RIGHT:
                        begin
                            r_act   = 1'b1;
                            r_goal  = turn_cfg;
                            r_dir   = (b == CMD_LEFT);
                            turn_on = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
        else
        begin
            ms_count = ms_count + 16'd1;
            if (ms_count == period_cfg)
            begin
                ms_count = '0;
                if (r_act)
                begin
                    // the turn holds the left driver enabled
                    if (turn_on)
                        l_en_n = 1'b0;
                    if (r_steps < r_goal)
                    begin
                        r_en_n  = 1'b0;
                        r_steps = r_steps + 16'd1;
                        rp      = 1'b1;
                    end
                    else
                    begin
                        r_act   = 1'b0;
                        r_steps = '0;
                        r_en_n  = hold;
                        if (turn_on)
                        begin
                            turn_on = 1'b0;
                            l_en_n  = 1'b1;
                        end
                    end
                end
                if (l_act)
                begin
                    if (l_steps < l_goal)
                    begin
                        l_en_n  = 1'b0;
                        l_steps = l_steps + 16'd1;
                        lp      = 1'b1;
                    end
                    else
                    begin
                        l_act   = 1'b0;
                        l_steps = '0;
                        l_en_n  = hold;
                    end
                end
            end
        end
        return '{rp, lp, r_dir, l_dir, r_en_n, l_en_n, r_act, l_act, turn_on};
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] b, input logic hold,
                             input logic typed = 1'b0, input motor_levels_t want = AT_REST);
        motor_levels_t lv;
        while (!steady && $urandom_range(99) < 27)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= kind;
        item_ch.rx_byte     <= b;
        item_ch.hold_switch <= hold;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        lv = predict_levels(kind, b, hold);
        pending_levels.push_back(typed ? want : lv);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_registers(input logic [15:0] p, input logic [15:0] d,
                                   input logic [15:0] t);
        logic [15:0] vals [3];
        vals[0] = p;
        vals[1] = d;
        vals[2] = t;
        cfg_ch.valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_ch.index <= reg_order[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            case (reg_order[i])
                CFG_TICK_PERIOD: period_cfg = vals[i];
                CFG_DRIVE_STEPS: drive_cfg  = vals[i];
                CFG_TURN_STEPS:  turn_cfg   = vals[i];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin : result_sink
        int hold_off_seen;
        int hold_off_left;
        hold_off_seen   = 0;
        hold_off_left   = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_asked != hold_off_seen)
            begin
                hold_off_seen = hold_off_asked;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    initial
    begin : result_check
        motor_levels_t got;
        motor_levels_t want_lv;
        int            beat_no;
        beat_no = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.right_pulse, result_ch.left_pulse,
                        result_ch.right_direction, result_ch.left_direction,
                        result_ch.right_enable_n, result_ch.left_enable_n,
                        result_ch.right_running, result_ch.left_running,
                        result_ch.turning};
                beat_no++;
                if (pending_levels.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("beat %0d: result with nothing pending, got %b", beat_no, got);
                end
                else
                begin
                    want_lv = pending_levels.pop_front();
                    if (got !== want_lv)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("beat %0d: expected %b got %b %s", beat_no, want_lv, got,
                                     "[pulse r l, dir r l, enable_n r l, running r l, turning]");
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("dual_stepper_command_pulser verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         sent;
        int         burst;
        int         roll;
        bit         asked_hold;
        bit         paused;
        logic [7:0] pick;

        script = '{
            '{KIND_TICK, 8'h00,       1'b0, 1'b1, AT_REST},
            '{KIND_BYTE, 8'h00,       1'b0, 1'b1, AT_REST},
            '{KIND_BYTE, 8'hff,       1'b1, 1'b1, AT_REST},
            '{KIND_BYTE, 8'h80,       1'b0, 1'b1, AT_REST},      // bad header, frame dropped
            '{KIND_BYTE, HDR_FIRST,   1'b1, 1'b1, AT_REST},
            '{KIND_BYTE, HDR_QUIET,   1'b0, 1'b1, AT_REST},
            '{KIND_BYTE, CMD_FORWARD, 1'b1, 1'b1, AT_REST},      // quiet frame, no effect
            '{KIND_BYTE, HDR_FIRST,   1'b0, 1'b1, AT_REST},
            '{KIND_BYTE, HDR_SECOND,  1'b0, 1'b1, AT_REST},
            '{KIND_BYTE, 8'h61,       1'b1, 1'b1, AT_REST},      // unknown letter
            '{KIND_BYTE, HDR_FIRST,   1'b0, 1'b0, AT_REST},
            '{KIND_BYTE, HDR_SECOND,  1'b0, 1'b0, AT_REST},
            '{KIND_BYTE, CMD_STOP,    1'b0, 1'b0, AT_REST},
            '{KIND_TICK, 8'h00,       1'b0, 1'b1, STOPPED_HELD}, // stop ends on the opportunity
            '{KIND_BYTE, HDR_FIRST,   1'b0, 1'b0, AT_REST},
            '{KIND_BYTE, HDR_SECOND,  1'b1, 1'b0, AT_REST},
            '{KIND_BYTE, CMD_FORWARD, 1'b0, 1'b0, AT_REST},
            '{KIND_TICK, 8'h5a,       1'b1, 1'b0, AT_REST},
            '{KIND_TICK, 8'ha5,       1'b0, 1'b0, AT_REST},
            '{KIND_BYTE, HDR_FIRST,   1'b1, 1'b0, AT_REST},
            '{KIND_BYTE, HDR_SECOND,  1'b0, 1'b0, AT_REST},
            '{KIND_BYTE, CMD_LEFT,    1'b1, 1'b0, AT_REST},
            '{KIND_TICK, 8'h00,       1'b1, 1'b0, AT_REST},
            '{KIND_TICK, 8'hff,       1'b0, 1'b0, AT_REST}
        };

        reset_model();
        item_ch.valid       <= 1'b0;
        item_ch.kind        <= KIND_TICK;
        item_ch.rx_byte     <= '0;
        item_ch.hold_switch <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_TICK_PERIOD;
        cfg_ch.data         <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_item(script[i].kind, script[i].val, script[i].hold, script[i].typed,
                      script[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // park the tick counter above the next, lower period
            if (ph == 4)
                while (ms_count != 16'd4)
                    send_item(KIND_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
            wait_drained();
            write_registers(ph_period[ph], ph_drive[ph], ph_turn[ph]);
            steady     = (ph == 3);
            sent       = 0;
            asked_hold = 1'b0;
            paused     = 1'b0;
            while (sent < ph_items[ph])
            begin
                if (ph == 0 && !asked_hold && sent >= 150)
                begin
                    hold_off_asked++;
                    asked_hold = 1'b1;
                end
                if (ph == 0 && !paused && sent >= 350)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                roll = $urandom_range(99);
                if (roll < 50)
                begin
                    burst = $urandom_range(6, 1);
                    repeat (burst)
                        send_item(KIND_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
                    sent += burst;
                end
                else if (roll < 87)
                begin
                    // realign to a frame boundary first
                    while (byte_slot != 2'd0)
                    begin
                        send_item(KIND_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
                        sent++;
                    end
                    send_item(KIND_BYTE, HDR_FIRST, 1'($urandom_range(1)));
                    if (roll < 80)
                    begin
                        send_item(KIND_BYTE, HDR_SECOND, 1'($urandom_range(1)));
                        pick = ($urandom_range(99) < 85) ? cmd_menu[$urandom_range(4)]
                                                         : 8'($urandom_range(255));
                    end
                    else
                    begin
                        send_item(KIND_BYTE, HDR_QUIET, 1'($urandom_range(1)));
                        pick = 8'($urandom_range(255));
                    end
                    send_item(KIND_BYTE, pick, 1'($urandom_range(1)));
                    sent += 3;
                end
                else if (roll < 94)
                begin
                    send_item(KIND_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
                    sent++;
                end
                else
                begin
                    // header cut short by a tick-free noise byte
                    send_item(KIND_BYTE, HDR_FIRST, 1'($urandom_range(1)));
                    send_item(KIND_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
                    sent += 2;
                end
            end
        end

        steady = 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        if (fault_count == 0 && pending_levels.size() == 0)
            $display("dual_stepper_command_pulser verification clean");
        else
            $display("dual_stepper_command_pulser verification failed");
        $finish;
    end

endmodule
